FILE: hw/rtl/seg4_pkg.sv
// package for the four-digit seven-segment driver
// shared types, op and register codes, glyph lookup; no dependencies
package seg4_pkg;

    localparam int DIGIT_COUNT = 4;

    typedef logic [DIGIT_COUNT-1:0][3:0] t_digits;
    typedef logic [DIGIT_COUNT-1:0][7:0] t_patterns;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD_DEC = 2'd0;
    localparam t_op OP_LOAD_HEX = 2'd1;
    localparam t_op OP_TICK     = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GLYPH_LOW  = 2'd0;
    localparam t_cfg_idx CFG_GLYPH_HIGH = 2'd1;
    localparam t_cfg_idx CFG_POINT_MASK = 2'd2;

    localparam logic [7:0]  PAT_BLANK       = 8'hFF;
    localparam logic [7:0]  POINT_MASK_RST  = 8'hEF;
    localparam logic [13:0] DEC_MAX         = 14'd9999;

    // glyph for one hex digit out of the two 64-bit table registers
    function automatic logic [7:0] glyph(input logic [63:0] tbl_low,
                                         input logic [63:0] tbl_high,
                                         input logic [3:0]  d);
        logic [63:0] tbl;
        tbl = d[3] ? tbl_high : tbl_low;
        return tbl[{d[2:0], 3'b000} +: 8];
    endfunction

endpackage

FILE: hw/rtl/seg4_split.sv
// digit split: decimal (saturating, reciprocal multiply) or hex nibbles
// depends on seg4_pkg
module seg4_split (
    input  logic [15:0]       i_value,
    input  logic              i_hex,
    output seg4_pkg::t_digits o_digits
);

    logic [13:0] w_dec;
    logic [27:0] w_prod_k;   // v * 8389  >> 23 = v / 1000
    logic [26:0] w_prod_h;   // v * 5243  >> 19 = v / 100
    logic [29:0] w_prod_t;   // v * 52429 >> 19 = v / 10
    logic [3:0]  w_thou;
    logic [6:0]  w_hund;
    logic [9:0]  w_tens;
    logic [6:0]  w_d2;
    logic [9:0]  w_d1;
    logic [13:0] w_d0;

    assign w_dec = (i_value > 16'(seg4_pkg::DEC_MAX)) ? seg4_pkg::DEC_MAX : i_value[13:0];

    assign w_prod_k = 28'(w_dec) * 28'd8389;
    assign w_prod_h = 27'(w_dec) * 27'd5243;
    assign w_prod_t = 30'(w_dec) * 30'd52429;

    assign w_thou = w_prod_k[26:23];
    assign w_hund = w_prod_h[25:19];
    assign w_tens = w_prod_t[28:19];

    // remainders by times-ten via shift and add
    assign w_d2 = w_hund - ({w_thou, 3'b000} + {2'b00, w_thou, 1'b0});
    assign w_d1 = w_tens - ({w_hund, 3'b000} + {2'b00, w_hund, 1'b0});
    assign w_d0 = w_dec  - ({1'b0, w_tens, 3'b000} + {3'b000, w_tens, 1'b0});

    always_comb begin
        if (i_hex) begin
            o_digits = i_value;
        end else begin
            o_digits[3] = w_thou;
            o_digits[2] = w_d2[3:0];
            o_digits[1] = w_d1[3:0];
            o_digits[0] = w_d0[3:0];
        end
    end

endmodule

FILE: hw/rtl/seg4_encode.sv
// glyph lookup, leading-zero blanking and decimal point per digit
// depends on seg4_pkg
module seg4_encode (
    input  seg4_pkg::t_digits   i_digits,
    input  logic [2:0]          i_point_pos,
    input  logic                i_units_always,
    input  logic [63:0]         i_glyph_low,
    input  logic [63:0]         i_glyph_high,
    input  logic [7:0]          i_point_mask,
    output seg4_pkg::t_patterns o_patterns
);

    always_comb begin
        logic       higher_on;
        logic       at_point;
        logic       on;
        logic [7:0] pat;
        higher_on = 1'b0;
        o_patterns = '{default: seg4_pkg::PAT_BLANK};
        for (int i = seg4_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
            at_point = (i_point_pos == 3'(i));
            on = (i_digits[i] != 4'd0) || higher_on || at_point
                 || ((i == 0) && i_units_always);
            pat = on ? seg4_pkg::glyph(i_glyph_low, i_glyph_high, i_digits[i])
                     : seg4_pkg::PAT_BLANK;
            if (on && at_point) begin
                pat = pat & i_point_mask;
            end
            o_patterns[i] = pat;
            higher_on = on;
        end
    end

endmodule

FILE: hw/rtl/seven_segment_four_digit_driver.sv
// top level of the four-digit multiplexed seven-segment driver
// depends on seg4_pkg, seg4_split, seg4_encode
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  in       | sink      | i_in_valid / o_in_ready   | i_op, i_value, i_point_pos
//  out      | source    | o_out_valid / i_out_ready | o_digit_select, o_segments
//  cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one beat a cycle while no tick is held: a beat lands in the input register, and the
// combinational split and glyph logic after it either writes the four digit registers
// (load) or fills the output register (tick)
// synchronous active-low reset blanks all digits, zeroes the scan index and tables
// a tick waits in the input register only while the output register is full and
// stalled; loads and ignored codes never wait
module seven_segment_four_digit_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_point_pos,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_digit_select,
    output logic [7:0]  o_segments,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // configuration registers
    logic [63:0] r_glyph_low;
    logic [63:0] r_glyph_high;
    logic [7:0]  r_point_mask;

    // input register
    logic              r_in_valid;
    seg4_pkg::t_op     r_op;
    logic [15:0]       r_value;
    logic [2:0]        r_point_pos;

    // display state
    seg4_pkg::t_patterns r_digit_pat;
    logic [1:0]          r_scan_idx;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_digit_select;
    logic [7:0]  r_segments;

    logic                w_out_free;
    logic                w_advance;
    logic                w_is_load;
    seg4_pkg::t_digits   w_digits;
    seg4_pkg::t_patterns w_patterns;

    // the output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && ((r_op != seg4_pkg::OP_TICK) || w_out_free);
    assign w_is_load  = (r_op == seg4_pkg::OP_LOAD_DEC) || (r_op == seg4_pkg::OP_LOAD_HEX);

    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // configuration writes, out-of-range index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_low  <= '0;
            r_glyph_high <= '0;
            r_point_mask <= seg4_pkg::POINT_MASK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                seg4_pkg::CFG_GLYPH_LOW:  r_glyph_low  <= i_cfg_data;
                seg4_pkg::CFG_GLYPH_HIGH: r_glyph_high <= i_cfg_data;
                seg4_pkg::CFG_POINT_MASK: r_point_mask <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op        <= i_op;
            r_value     <= i_value;
            r_point_pos <= i_point_pos;
        end
    end

    // digit split and pattern generation
    seg4_split u_split (
        .i_value  (r_value),
        .i_hex    (r_op == seg4_pkg::OP_LOAD_HEX),
        .o_digits (w_digits)
    );

    seg4_encode u_encode (
        .i_digits       (w_digits),
        .i_point_pos    (r_point_pos),
        .i_units_always (r_op == seg4_pkg::OP_LOAD_DEC),
        .i_glyph_low    (r_glyph_low),
        .i_glyph_high   (r_glyph_high),
        .i_point_mask   (r_point_mask),
        .o_patterns     (w_patterns)
    );

    // digit registers and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_pat <= '{default: seg4_pkg::PAT_BLANK};
            r_scan_idx  <= '0;
        end else if (w_advance) begin
            if (w_is_load) begin
                r_digit_pat <= w_patterns;
            end
            if (r_op == seg4_pkg::OP_TICK) begin
                r_scan_idx <= r_scan_idx + 2'd1;
            end
        end
    end

    // output register, filled by a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && (r_op == seg4_pkg::OP_TICK)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && (r_op == seg4_pkg::OP_TICK)) begin
            r_digit_select <= 4'b0001 << r_scan_idx;
            r_segments     <= r_digit_pat[r_scan_idx];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_digit_select = r_digit_select;
    assign o_segments     = r_segments;

`ifndef SYNTHESIS
    // a result beat always lights exactly one digit
    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(o_digit_select))
        else $error("digit select not one-hot");

    // every tick that leaves the input register moves the scan on by one
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_op == seg4_pkg::OP_TICK))
        |=> (r_scan_idx == 2'($past(r_scan_idx) + 2'd1)))
        else $error("scan index did not advance on tick");

    // a held tick keeps its beat in the input register
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_op)))
        else $error("stalled input beat lost");
`endif

endmodule

FILE: tb/seg4_checker.sv
// checker for the four-digit seven-segment driver: watches the item, result and
// register channels, predicts every scan beat and compares; depends on seg4_pkg
`timescale 1ns / 1ps

module seg4_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_point_pos,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_digit_select,
    input  logic [7:0]  i_segments,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [3:0] select;
        logic [7:0] segs;
    } t_scan_beat;

    logic [63:0] glyph_lo;
    logic [63:0] glyph_hi;
    logic [7:0]  dp_mask;
    logic [7:0]  shown [seg4_pkg::DIGIT_COUNT];
    logic [1:0]  scan_pos;

    t_scan_beat  scan_expected [$];
    t_scan_beat  want;
    int          fails = 0;
    int          beat_no = 0;

    function automatic logic [7:0] glyph_of(input logic [3:0] d);
        if (d < 4'd8) begin
            return glyph_lo[8 * int'(d) +: 8];
        end
        return glyph_hi[8 * (int'(d) - 8) +: 8];
    endfunction

    function automatic seg4_pkg::t_digits dec_split(input logic [15:0] value);
        int v;
        seg4_pkg::t_digits digs;
        v = (value > seg4_pkg::DEC_MAX) ? int'(seg4_pkg::DEC_MAX) : int'(value);
        digs[3] = 4'(v / 1000);
        digs[2] = 4'((v / 100) % 10);
        digs[1] = 4'((v / 10) % 10);
        digs[0] = 4'(v % 10);
        return digs;
    endfunction

    // leading zeros blank; point digit, all below it and, if units_on, the units digit lit
    function automatic void load_digits(input seg4_pkg::t_digits digs,
                                        input logic [2:0] pt,
                                        input logic units_on);
        logic       lit_above;
        logic       lit;
        logic       at_pt;
        logic [7:0] pat;
        lit_above = 1'b0;
        for (int i = seg4_pkg::DIGIT_COUNT - 1; i >= 0; i--) begin
            at_pt = (int'(pt) == i);
            if (digs[i] != 4'd0) begin
                pat = glyph_of(digs[i]);
                lit = 1'b1;
            end else if (lit_above || at_pt || (i == 0 && units_on)) begin
                pat = glyph_of(4'd0);
                lit = 1'b1;
            end else begin
                pat = seg4_pkg::PAT_BLANK;
                lit = 1'b0;
            end
            if (lit && at_pt) begin
                pat = pat & dp_mask;
            end
            shown[i] = pat;
            lit_above = lit;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            glyph_lo = '0;
            glyph_hi = '0;
            dp_mask  = seg4_pkg::POINT_MASK_RST;
            for (int i = 0; i < seg4_pkg::DIGIT_COUNT; i++) begin
                shown[i] = seg4_pkg::PAT_BLANK;
            end
            scan_pos = '0;
            scan_expected.delete();
        end else begin
            // result side first so a stray beat is never matched by this cycle's item
            if (i_out_valid && i_out_ready) begin
                beat_no++;
                if (scan_expected.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("result beat %0d unexpected: select %h segments %h",
                                 beat_no, i_digit_select, i_segments);
                    end
                end else begin
                    want = scan_expected.pop_front();
                    if (i_digit_select !== want.select || i_segments !== want.segs) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"result beat %0d: select exp %h got %h, ",
                                      "segments exp %h got %h"},
                                     beat_no, want.select, i_digit_select,
                                     want.segs, i_segments);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    seg4_pkg::CFG_GLYPH_LOW:  glyph_lo = i_cfg_data;
                    seg4_pkg::CFG_GLYPH_HIGH: glyph_hi = i_cfg_data;
                    seg4_pkg::CFG_POINT_MASK: dp_mask  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    seg4_pkg::OP_LOAD_DEC:
                        load_digits(dec_split(i_value), i_point_pos, 1'b1);
                    seg4_pkg::OP_LOAD_HEX:
                        load_digits(seg4_pkg::t_digits'(i_value), i_point_pos, 1'b0);
                    seg4_pkg::OP_TICK: begin
                        want.select = 4'b0001 << scan_pos;
                        want.segs   = shown[scan_pos];
                        scan_expected.push_back(want);
                        scan_pos = scan_pos + 2'd1;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= scan_expected.size();
    end

endmodule

FILE: tb/tb.sv
// testbench top for the four-digit seven-segment driver: clock, reset, stimulus
// and verdict; depends on seg4_pkg, the driver RTL and seg4_checker
`timescale 1ns / 1ps

module tb;

    // codes the block must ignore
    localparam seg4_pkg::t_op      OP_NONE   = 2'd3;
    localparam seg4_pkg::t_cfg_idx CFG_SPARE = 2'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 165;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [15:0] i_value;
    logic [2:0]  i_point_pos;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_digit_select;
    logic [7:0]  o_segments;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int fail_count;
    int pending;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    seven_segment_four_digit_driver u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_point_pos    (i_point_pos),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    seg4_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_point_pos    (i_point_pos),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_digit_select (o_digit_select),
        .i_segments     (o_segments),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one item beat; entered and left on a falling edge, valid left high so the
    // next beat can follow back to back
    task automatic send_item(input logic [1:0] op, input logic [15:0] value,
                             input logic [2:0] pt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_value     <= value;
        i_point_pos <= pt;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // one register beat; caller drops cfg valid after the last one
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // drain all scan beats, then allow the pipe to empty of loads
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // knobs change just after a rising edge so the falling-edge draw never races them
    task automatic set_pressure(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        @(negedge i_clk);
    endtask

    initial begin
        int          r;
        logic [1:0]  op;
        logic [15:0] val;
        logic [2:0]  pt;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] msk;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = seg4_pkg::OP_LOAD_DEC;
        i_value     = '0;
        i_point_pos = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = seg4_pkg::CFG_GLYPH_LOW;
        i_cfg_data  = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---------------- directed part ----------------
        // a tick straight out of reset shows the blank pattern
        send_item(seg4_pkg::OP_TICK, 16'hFFFF, 3'd7);
        settle();

        // ordinary active-low glyphs, point on bit 7; spare index must be ignored
        write_reg(seg4_pkg::CFG_GLYPH_LOW,  64'hF882_9299_B0A4_F9C0);
        write_reg(seg4_pkg::CFG_GLYPH_HIGH, 64'h8E86_A1C6_8388_9080);
        write_reg(seg4_pkg::CFG_POINT_MASK, 64'hFFFF_FFFF_FFFF_FF7F);
        write_reg(CFG_SPARE,                '1);
        i_cfg_valid <= 1'b0;

        // decimal zero still lights the units digit
        send_item(seg4_pkg::OP_LOAD_DEC, 16'd0, 3'd4);
        repeat (4) send_item(seg4_pkg::OP_TICK, 16'($urandom), 3'($urandom));
        // decimal overflow saturates, point on the units digit
        send_item(seg4_pkg::OP_LOAD_DEC, 16'hFFFF, 3'd0);
        repeat (4) send_item(seg4_pkg::OP_TICK, 16'($urandom), 3'($urandom));
        // hex zero with no point is fully blank; op three changes nothing
        send_item(seg4_pkg::OP_LOAD_HEX, 16'h0000, 3'd4);
        send_item(OP_NONE, 16'hFFFF, 3'd0);
        repeat (4) send_item(seg4_pkg::OP_TICK, 16'($urandom), 3'($urandom));
        // every digit at fifteen, point on the top digit
        send_item(seg4_pkg::OP_LOAD_HEX, 16'hFFFF, 3'd3);
        repeat (4) send_item(seg4_pkg::OP_TICK, 16'($urandom), 3'($urandom));
        // point forces a zero digit on above a small value
        send_item(seg4_pkg::OP_LOAD_DEC, 16'd7, 3'd2);
        repeat (2) send_item(seg4_pkg::OP_TICK, 16'h0000, 3'd0);
        // point position four or above behaves as no point
        send_item(seg4_pkg::OP_LOAD_HEX, 16'h00A0, 3'd7);
        repeat (2) send_item(seg4_pkg::OP_TICK, 16'h0000, 3'd0);

        // ---------------- random part ----------------
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase % 4)
                0: set_pressure(0, 0);
                1: set_pressure(70, 0);
                2: set_pressure(0, 70);
                default: set_pressure(36, 36);
            endcase

            // tables: random, all ones with a closed mask, all zero with an open mask
            case (phase % 3)
                0: begin
                    lo  = {$urandom, $urandom};
                    hi  = {$urandom, $urandom};
                    msk = {$urandom, $urandom};
                end
                1: begin
                    lo  = '1;
                    hi  = '1;
                    msk = 64'hFFFF_FFFF_FFFF_FF00;
                end
                default: begin
                    lo  = '0;
                    hi  = '0;
                    msk = 64'h0000_0000_0000_00FF;
                end
            endcase
            write_reg(seg4_pkg::CFG_GLYPH_LOW,  lo);
            write_reg(seg4_pkg::CFG_GLYPH_HIGH, hi);
            write_reg(seg4_pkg::CFG_POINT_MASK, msk);
            if (phase % 2 == 1) begin
                write_reg(CFG_SPARE, {$urandom, $urandom});
            end
            i_cfg_valid <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r  = $urandom_range(99);
                pt = ($urandom_range(2) == 0) ? 3'd4 : 3'($urandom_range(7));
                if (r < 5) begin
                    op  = OP_NONE;
                    val = 16'($urandom);
                end else if (r < 50) begin
                    op  = seg4_pkg::OP_TICK;
                    val = 16'($urandom);
                end else if (r < 75) begin
                    op = seg4_pkg::OP_LOAD_DEC;
                    case ($urandom_range(3))
                        0: val = 16'($urandom_range(99));
                        1: val = 16'($urandom_range(10010, 9990));
                        2: val = 16'($urandom);
                        default: val = 16'($urandom_range(9999));
                    endcase
                end else begin
                    op = seg4_pkg::OP_LOAD_HEX;
                    case ($urandom_range(2))
                        0: val = 16'($urandom_range(255));
                        1: val = 16'($urandom);
                        default: val = 16'($urandom_range(15) << (4 * $urandom_range(3)));
                    endcase
                end
                send_item(op, val, pt);
            end
        end

        // ---------------- drain and verdict ----------------
        i_in_valid <= 1'b0;
        set_pressure(0, 0);
        for (int n = 0; n < 2000 && pending != 0; n++) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: seven_segment_four_digit_driver.f
hw/rtl/seg4_pkg.sv
hw/rtl/seg4_split.sv
hw/rtl/seg4_encode.sv
hw/rtl/seven_segment_four_digit_driver.sv
tb/seg4_checker.sv
tb/tb.sv
